// ===== hdl/mlfq_pkg.sv =====
// Shared types, constants and codes of the three-level feedback-queue scheduler.
package mlfq_pkg;

  // Table size and derived widths.
  localparam int NUM_CELLS = 16;
  localparam int IDX_W     = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int CNT_W     = $clog2(NUM_CELLS + 1);

  // Fixed field widths.
  localparam int TIME_W  = 24;
  localparam int ARR_W   = 16;
  localparam int BURST_W = 16;
  localparam int QNT_W   = 16;
  localparam int LVL_W   = 2;
  localparam int CMD_W   = 2;
  localparam int KIND_W  = 2;
  localparam int PID_W   = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = QNT_W;

  // Input commands.
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STEP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Slice record kinds.
  localparam logic [KIND_W-1:0] KIND_IDLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RAN  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;

  // Queue levels.
  localparam logic [LVL_W-1:0] LVL_ONE = 2'd1;
  localparam logic [LVL_W-1:0] LVL_TWO = 2'd2;
  localparam logic [LVL_W-1:0] LVL_TOP = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_ONE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_TWO = 1'b1;

  // Quantum reset values.
  localparam logic [QNT_W-1:0] QUANTUM_ONE_RST = 16'd4;
  localparam logic [QNT_W-1:0] QUANTUM_TWO_RST = 16'd8;

  // Operation broadcast to the cells.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_LOAD,
    OP_UPD,
    OP_CLEAR
  } cell_op_t;

  // Best candidate handed from cell to cell, with the whole entry it names.
  typedef struct packed {
    logic               found;
    logic [IDX_W-1:0]   idx;
    logic [LVL_W-1:0]   level;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] remaining;
    logic               started;
    logic [TIME_W-1:0]  response;
  } cand_t;

  localparam cand_t CAND_NONE = '0;

  // Write command broadcast to the cells.
  typedef struct packed {
    cell_op_t           op;
    logic [IDX_W-1:0]   tgt;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] remaining;
    logic [LVL_W-1:0]   level;
    logic [TIME_W-1:0]  response;
  } cell_cmd_t;

endpackage

// ===== hdl/mlfq_if.sv =====
// Valid/ready channel interfaces for command items and slice record items.
interface mlfq_in_if;
  import mlfq_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [ARR_W-1:0]   arrival_time;
  logic [BURST_W-1:0] burst_time;

  modport source (output valid, output cmd, output arrival_time, output burst_time,
                  input ready);
  modport sink   (input valid, input cmd, input arrival_time, input burst_time,
                  output ready);
endinterface

interface mlfq_out_if;
  import mlfq_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] slice_kind;
  logic [PID_W-1:0]  process_id;
  logic [TIME_W-1:0] start_tick;
  logic [TIME_W-1:0] end_tick;
  logic [LVL_W-1:0]  queue_level;
  logic              finished;
  logic [TIME_W-1:0] turnaround;
  logic [TIME_W-1:0] waiting;
  logic [TIME_W-1:0] response;

  modport source (output valid, output slice_kind, output process_id, output start_tick,
                  output end_tick, output queue_level, output finished,
                  output turnaround, output waiting, output response, input ready);
  modport sink   (input valid, input slice_kind, input process_id, input start_tick,
                  input end_tick, input queue_level, input finished,
                  input turnaround, input waiting, input response, output ready);
endinterface

// ===== hdl/mlfq_cell.sv =====
// One process table entry that also stage-registers the running best candidate.
module mlfq_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [mlfq_pkg::IDX_W-1:0]    cell_idx,
  input  logic [mlfq_pkg::CNT_W-1:0]    loaded_count,
  input  logic [mlfq_pkg::TIME_W-1:0]   now,
  input  mlfq_pkg::cell_cmd_t           cmd,
  input  mlfq_pkg::cand_t               cand_in,
  output mlfq_pkg::cand_t               cand_out
);
  import mlfq_pkg::*;

  logic [ARR_W-1:0]   arrival_r;
  logic [BURST_W-1:0] burst_r;
  logic [BURST_W-1:0] remaining_r;
  logic [LVL_W-1:0]   level_r;
  logic [TIME_W-1:0]  response_r;
  logic               started_r;
  cand_t              cand_r;
  cand_t              cand_nxt;
  logic               hit;
  logic               eligible;
  logic               take;

  // This entry wins over the incoming candidate only at a strictly lower level,
  // so on equal levels the lower table index keeps the slot.
  always_comb begin
    hit      = (cmd.tgt == cell_idx);
    eligible = (CNT_W'(cell_idx) < loaded_count) && (remaining_r != '0) &&
               (TIME_W'(arrival_r) <= now);
    take     = eligible && (!cand_in.found || (level_r < cand_in.level));
    cand_nxt = cand_in;
    if (take) begin
      cand_nxt.found     = 1'b1;
      cand_nxt.idx       = cell_idx;
      cand_nxt.level     = level_r;
      cand_nxt.arrival   = arrival_r;
      cand_nxt.burst     = burst_r;
      cand_nxt.remaining = remaining_r;
      cand_nxt.started   = started_r;
      cand_nxt.response  = response_r;
    end
  end

  // First-dispatch flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_LOAD:  if (hit) started_r <= 1'b0;
        OP_UPD:   if (hit) started_r <= 1'b1;
        OP_CLEAR: started_r <= 1'b0;
        default:  ;
      endcase
    end
  end

  // Entry payload and the candidate stage.
  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
    if (hit && (cmd.op == OP_LOAD)) begin
      arrival_r   <= cmd.arrival;
      burst_r     <= cmd.burst;
      remaining_r <= cmd.burst;
      level_r     <= LVL_ONE;
      response_r  <= '0;
    end else if (hit && (cmd.op == OP_UPD)) begin
      remaining_r <= cmd.remaining;
      level_r     <= cmd.level;
      response_r  <= cmd.response;
    end
  end

  assign cand_out = cand_r;

endmodule

// ===== hdl/mlfq_cpu_scheduler_top.sv =====
// Top level of the three-level feedback-queue scheduler: control, timing and the cell row.
//
// Processes live in a row of NUM_CELLS cells, one table entry per cell. A step
// command sends the best ready candidate down the row, one cell per clock. A step
// runs in order through the accept, the pass along the cell row, a stage that sizes
// the slice and one that writes the entry back and loads the output register. A step
// with every process complete goes from the accept straight to the write-back.
// Load and clear items give no result. A new item is accepted only once the
// previous one is done, and a step waits in its last cycle while the previous slice
// record still sits unread in the output register. The quantum registers take a
// write in any cycle the block is idle.
module mlfq_cpu_scheduler_top (
  input  logic                              clk,
  input  logic                              rst_n,
  mlfq_in_if.sink                           in_chan,
  mlfq_out_if.source                        out_chan,
  input  logic                              cfg_we,
  input  logic [mlfq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mlfq_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mlfq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SLICE,
    S_UPD
  } state_t;

  state_t             state_r;
  logic [IDX_W-1:0]   scan_cnt_r;
  logic [CNT_W-1:0]   loaded_cnt_r;
  logic [CNT_W-1:0]   fin_cnt_r;
  logic [TIME_W-1:0]  time_r;
  logic               done_r;
  logic [QNT_W-1:0]   quantum_one_r;
  logic [QNT_W-1:0]   quantum_two_r;

  // Slice stage results.
  logic [TIME_W-1:0]  new_time_r;
  logic [BURST_W-1:0] rem_new_r;
  logic [TIME_W-1:0]  resp_r;
  logic [ARR_W:0]     apb_r;

  // Output register.
  logic               out_valid_r;
  logic [KIND_W-1:0]  out_kind_r;
  logic [PID_W-1:0]   out_pid_r;
  logic [TIME_W-1:0]  out_start_r;
  logic [TIME_W-1:0]  out_end_r;
  logic [LVL_W-1:0]   out_level_r;
  logic               out_fin_r;
  logic [TIME_W-1:0]  out_tat_r;
  logic [TIME_W-1:0]  out_wait_r;
  logic [TIME_W-1:0]  out_resp_r;

  cand_t              chain [NUM_CELLS];
  cand_t              win;
  cell_cmd_t          cell_cmd;
  logic               in_acc;
  logic               out_free;
  logic               load_ok;
  logic               leave_upd;
  logic [BURST_W-1:0] slice;
  logic [BURST_W-1:0] advance;
  logic [TIME_W:0]    sum;
  logic [TIME_W-1:0]  new_time_c;
  logic               fin;
  logic [TIME_W-1:0]  tat;
  logic [TIME_W-1:0]  wait_c;
  logic [LVL_W-1:0]   level_nxt;

  assign in_chan.ready = (state_r == S_IDLE);
  assign win           = chain[NUM_CELLS-1];

  // Row of table cells; cell 0 starts from an empty candidate.
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    mlfq_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .cell_idx     (IDX_W'(k)),
      .loaded_count (loaded_cnt_r),
      .now          (time_r),
      .cmd          (cell_cmd),
      .cand_in      ((k == 0) ? CAND_NONE : chain[(k == 0) ? 0 : k - 1]),
      .cand_out     (chain[k])
    );
  end

  // Handshake qualifiers.
  always_comb begin
    in_acc    = in_chan.valid && in_chan.ready;
    out_free  = !out_valid_r || out_chan.ready;
    load_ok   = (loaded_cnt_r < CNT_W'(NUM_CELLS)) && (in_chan.burst_time != '0);
    leave_upd = (state_r == S_UPD) && out_free;
  end

  // Slice length and the new time, saturating at the top of the time range.
  always_comb begin
    slice = win.remaining;
    if ((win.level == LVL_ONE) && (win.remaining > quantum_one_r)) begin
      slice = quantum_one_r;
    end else if ((win.level == LVL_TWO) && (win.remaining > quantum_two_r)) begin
      slice = quantum_two_r;
    end
    advance    = win.found ? slice : BURST_W'(1);
    sum        = {1'b0, time_r} + (TIME_W + 1)'(advance);
    new_time_c = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
  end

  // Completion statistics and the demotion of an unfinished process.
  always_comb begin
    fin       = (rem_new_r == '0);
    tat       = new_time_r - TIME_W'(win.arrival);
    wait_c    = (new_time_r >= TIME_W'(apb_r)) ? (new_time_r - TIME_W'(apb_r)) : '0;
    level_nxt = win.level;
    if (!fin && (win.level < LVL_TOP)) begin
      level_nxt = win.level + LVL_W'(1);
    end
  end

  // Write command to the cells: loads and clears from idle, write-back at the end of a step.
  always_comb begin
    cell_cmd           = '0;
    cell_cmd.op        = OP_NONE;
    cell_cmd.arrival   = in_chan.arrival_time;
    cell_cmd.burst     = in_chan.burst_time;
    cell_cmd.remaining = rem_new_r;
    cell_cmd.level     = level_nxt;
    cell_cmd.response  = resp_r;
    cell_cmd.tgt       = loaded_cnt_r[IDX_W-1:0];
    if (in_acc && (in_chan.cmd == CMD_LOAD) && load_ok) begin
      cell_cmd.op = OP_LOAD;
    end else if (in_acc && (in_chan.cmd == CMD_CLEAR)) begin
      cell_cmd.op = OP_CLEAR;
    end else if (leave_upd && !done_r && win.found) begin
      cell_cmd.op  = OP_UPD;
      cell_cmd.tgt = win.idx;
    end
  end

  // Quantum registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_one_r <= QUANTUM_ONE_RST;
      quantum_two_r <= QUANTUM_TWO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_QUANTUM_ONE: quantum_one_r <= cfg_data;
        CFG_QUANTUM_TWO: quantum_two_r <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Slice stage registers.
  always_ff @(posedge clk) begin
    if (state_r == S_SLICE) begin
      new_time_r <= new_time_c;
      rem_new_r  <= win.remaining - slice;
      resp_r     <= win.started ? win.response : (time_r - TIME_W'(win.arrival));
      apb_r      <= {1'b0, win.arrival} + (ARR_W + 1)'(win.burst);
    end
  end

  // Sequencer, time keeping and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      scan_cnt_r   <= '0;
      loaded_cnt_r <= '0;
      fin_cnt_r    <= '0;
      time_r       <= '0;
      done_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // The record leaves when taken, unless a new one replaces it in the same cycle.
      if (out_valid_r && out_chan.ready && !leave_upd) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_chan.cmd)
              CMD_LOAD: begin
                if (load_ok) loaded_cnt_r <= loaded_cnt_r + CNT_W'(1);
              end
              CMD_CLEAR: begin
                loaded_cnt_r <= '0;
                fin_cnt_r    <= '0;
                time_r       <= '0;
              end
              CMD_STEP: begin
                done_r     <= (fin_cnt_r >= loaded_cnt_r);
                scan_cnt_r <= '0;
                state_r    <= (fin_cnt_r >= loaded_cnt_r) ? S_UPD : S_SCAN;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          scan_cnt_r <= scan_cnt_r + IDX_W'(1);
          if (scan_cnt_r == IDX_W'(NUM_CELLS - 1)) begin
            state_r <= S_SLICE;
          end
        end
        S_SLICE: begin
          state_r <= S_UPD;
        end
        S_UPD: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_start_r <= time_r;
            out_pid_r   <= '0;
            out_level_r <= '0;
            out_fin_r   <= 1'b0;
            out_tat_r   <= '0;
            out_wait_r  <= '0;
            out_resp_r  <= '0;
            if (done_r) begin
              out_kind_r <= KIND_DONE;
              out_end_r  <= time_r;
            end else begin
              time_r    <= new_time_r;
              out_end_r <= new_time_r;
              if (win.found) begin
                out_kind_r  <= KIND_RAN;
                out_pid_r   <= PID_W'(win.idx) + PID_W'(1);
                out_level_r <= win.level;
                out_fin_r   <= fin;
                if (fin) begin
                  out_tat_r  <= tat;
                  out_wait_r <= wait_c;
                  out_resp_r <= resp_r;
                  fin_cnt_r  <= fin_cnt_r + CNT_W'(1);
                end
              end else begin
                out_kind_r <= KIND_IDLE;
              end
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.slice_kind  = out_kind_r;
  assign out_chan.process_id  = out_pid_r;
  assign out_chan.start_tick  = out_start_r;
  assign out_chan.end_tick    = out_end_r;
  assign out_chan.queue_level = out_level_r;
  assign out_chan.finished    = out_fin_r;
  assign out_chan.turnaround  = out_tat_r;
  assign out_chan.waiting     = out_wait_r;
  assign out_chan.response    = out_resp_r;

  // More processes can never be finished than are loaded.
  a_fin_le_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    fin_cnt_r <= loaded_cnt_r)
    else $error("finished count exceeds loaded count");

  // Time only moves forward unless a clear item is taken.
  a_time_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && (in_chan.cmd == CMD_CLEAR)) |=> time_r >= $past(time_r))
    else $error("current time went backwards");

  // A slice record appears only as a step finishes its write-back.
  a_out_from_upd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_UPD)
    else $error("slice record without a finished step");

  // Leaving the write-back stage always presents a record.
  a_upd_emits: assert property (@(posedge clk) disable iff (!rst_n)
    leave_upd |=> out_valid_r && (state_r == S_IDLE))
    else $error("step ended without a slice record");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the three-level feedback-queue scheduler top level.
module tb;
  import mlfq_pkg::*;

  // One slice record as the block emits it.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PID_W-1:0]  pid;
    logic [TIME_W-1:0] start_t;
    logic [TIME_W-1:0] end_t;
    logic [LVL_W-1:0]  level;
    logic              done_flag;
    logic [TIME_W-1:0] tat;
    logic [TIME_W-1:0] wait_ticks;
    logic [TIME_W-1:0] resp;
  } slice_rec_t;

  // One row of the directed table; typed rows carry their record written out by hand.
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic               typed;
    slice_rec_t         rec;
  } dir_row_t;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [LVL_W-1:0] LVL_NONE   = 2'd0;
  localparam int unsigned MAX_TICK        = 32'h00FF_FFFF;
  localparam int NUM_DIRECTED = 18;
  localparam int NUM_PHASES   = 8;
  localparam int TOTAL_ITEMS  = 550;
  localparam int SETTLE_CYCLES = 25;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mlfq_in_if  in_if ();
  mlfq_out_if out_if ();

  mlfq_cpu_scheduler_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the process table, counters and quanta.
  logic [ARR_W-1:0]   proc_arrival   [NUM_CELLS];
  logic [BURST_W-1:0] proc_burst     [NUM_CELLS];
  logic [BURST_W-1:0] proc_remaining [NUM_CELLS];
  logic [LVL_W-1:0]   proc_level     [NUM_CELLS];
  logic [TIME_W-1:0]  proc_response  [NUM_CELLS];
  bit                 proc_started   [NUM_CELLS];
  int unsigned procs_loaded   = 0;
  int unsigned procs_finished = 0;
  int unsigned sched_time     = 0;
  logic [QNT_W-1:0] quantum_one = QUANTUM_ONE_RST;
  logic [QNT_W-1:0] quantum_two = QUANTUM_TWO_RST;

  slice_rec_t pending_slices[$];

  int items_sent = 0;
  int ignored_sent = 0;
  int mismatch_count = 0;
  int ran_slices = 0;
  int idle_slices = 0;
  int done_slices = 0;
  int completions = 0;
  bit calm = 1'b0;

  // Directed table: empty table, ignored items, idle ticks, every level, clear.
  dir_row_t directed_rows [NUM_DIRECTED] = '{
    '{CMD_STEP, 16'd0, 16'd0, 1'b1,
      '{KIND_DONE, 5'd0, 24'd0, 24'd0, LVL_NONE, 1'b0, 24'd0, 24'd0, 24'd0}},
    '{CMD_UNUSED, 16'hFFFF, 16'hFFFF, 1'b0, '0},
    '{CMD_LOAD, 16'd0, 16'd0, 1'b0, '0},
    '{CMD_LOAD, 16'd2, 16'd1, 1'b0, '0},
    '{CMD_STEP, 16'd0, 16'd0, 1'b1,
      '{KIND_IDLE, 5'd0, 24'd0, 24'd1, LVL_NONE, 1'b0, 24'd0, 24'd0, 24'd0}},
    '{CMD_STEP, 16'd0, 16'd0, 1'b1,
      '{KIND_IDLE, 5'd0, 24'd1, 24'd2, LVL_NONE, 1'b0, 24'd0, 24'd0, 24'd0}},
    '{CMD_STEP, 16'd0, 16'd0, 1'b1,
      '{KIND_RAN, 5'd1, 24'd2, 24'd3, LVL_ONE, 1'b1, 24'd1, 24'd0, 24'd0}},
    '{CMD_STEP, 16'd0, 16'd0, 1'b1,
      '{KIND_DONE, 5'd0, 24'd3, 24'd3, LVL_NONE, 1'b0, 24'd0, 24'd0, 24'd0}},
    '{CMD_LOAD, 16'd0, 16'hFFFF, 1'b0, '0},
    '{CMD_LOAD, 16'hFFFF, 16'd10, 1'b0, '0},
    '{CMD_STEP, 16'hFFFF, 16'hFFFF, 1'b0, '0},
    '{CMD_STEP, 16'd0, 16'd0, 1'b0, '0},
    '{CMD_STEP, 16'd0, 16'd0, 1'b0, '0},
    '{CMD_STEP, 16'd0, 16'd0, 1'b0, '0},
    '{CMD_STEP, 16'd0, 16'd0, 1'b0, '0},
    '{CMD_STEP, 16'd0, 16'd0, 1'b0, '0},
    '{CMD_CLEAR, 16'hFFFF, 16'hFFFF, 1'b0, '0},
    '{CMD_STEP, 16'd0, 16'd0, 1'b1,
      '{KIND_DONE, 5'd0, 24'd0, 24'd0, LVL_NONE, 1'b0, 24'd0, 24'd0, 24'd0}}
  };

  // Quantum settings per phase; the first keeps the reset values, the last is drawn.
  logic [QNT_W-1:0] phase_q1 [NUM_PHASES] = '{16'd4, 16'd1, 16'd65535, 16'd0,
                                              16'd0, 16'd2, 16'd65535, 16'd0};
  logic [QNT_W-1:0] phase_q2 [NUM_PHASES] = '{16'd8, 16'd1, 16'd65535, 16'd0,
                                              16'd3, 16'd0, 16'd1, 16'd0};

  // Applies one accepted item to the shadow table; returns 1 when it yields a slice record.
  function automatic bit schedule_item(input logic [CMD_W-1:0] cmd,
                                       input logic [ARR_W-1:0] arr,
                                       input logic [BURST_W-1:0] bst,
                                       output slice_rec_t rec);
    bit emits;
    int best;
    int best_lvl;
    int unsigned slice;
    int unsigned tat;
    emits = 1'b0;
    rec = '0;
    if (cmd == CMD_LOAD) begin
      if (procs_loaded < NUM_CELLS && bst != 0) begin
        proc_arrival[procs_loaded]   = arr;
        proc_burst[procs_loaded]     = bst;
        proc_remaining[procs_loaded] = bst;
        proc_level[procs_loaded]     = LVL_ONE;
        proc_response[procs_loaded]  = '0;
        proc_started[procs_loaded]   = 1'b0;
        procs_loaded++;
      end
    end else if (cmd == CMD_CLEAR) begin
      foreach (proc_started[i]) proc_started[i] = 1'b0;
      procs_loaded = 0;
      procs_finished = 0;
      sched_time = 0;
    end else if (cmd == CMD_STEP) begin
      emits = 1'b1;
      rec.start_t = TIME_W'(sched_time);
      if (procs_finished >= procs_loaded) begin
        rec.kind = KIND_DONE;
        rec.end_t = TIME_W'(sched_time);
      end else begin
        // Lowest level wins; the strict compare keeps the lowest index on ties.
        best = -1;
        best_lvl = 4;
        for (int i = 0; i < procs_loaded; i++) begin
          if (proc_remaining[i] != 0 && proc_arrival[i] <= sched_time &&
              proc_level[i] < best_lvl) begin
            best = i;
            best_lvl = proc_level[i];
          end
        end
        if (best < 0) begin
          sched_time = (sched_time + 1 > MAX_TICK) ? MAX_TICK : sched_time + 1;
          rec.kind = KIND_IDLE;
          rec.end_t = TIME_W'(sched_time);
        end else begin
          if (!proc_started[best]) begin
            proc_started[best] = 1'b1;
            proc_response[best] = TIME_W'(sched_time - proc_arrival[best]);
          end
          slice = proc_remaining[best];
          if (proc_level[best] == LVL_ONE && slice > quantum_one) begin
            slice = quantum_one;
          end else if (proc_level[best] == LVL_TWO && slice > quantum_two) begin
            slice = quantum_two;
          end
          sched_time = (sched_time + slice > MAX_TICK) ? MAX_TICK : sched_time + slice;
          proc_remaining[best] = BURST_W'(proc_remaining[best] - slice);
          rec.kind = KIND_RAN;
          rec.pid = PID_W'(best + 1);
          rec.end_t = TIME_W'(sched_time);
          rec.level = proc_level[best];
          if (proc_remaining[best] == 0) begin
            tat = sched_time - proc_arrival[best];
            rec.done_flag = 1'b1;
            rec.tat = TIME_W'(tat);
            rec.wait_ticks = (tat >= proc_burst[best]) ? TIME_W'(tat - proc_burst[best]) : '0;
            rec.resp = proc_response[best];
            procs_finished++;
          end else if (proc_level[best] < LVL_TOP) begin
            proc_level[best] = proc_level[best] + 1'b1;
          end
        end
      end
    end
    return emits;
  endfunction

  // Offers one item after a random gap and records what it should produce once accepted.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ARR_W-1:0] arr,
                           input logic [BURST_W-1:0] bst, input bit typed,
                           input slice_rec_t typed_rec);
    int gap;
    slice_rec_t rec;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.cmd          <= cmd;
    in_if.arrival_time <= arr;
    in_if.burst_time   <= bst;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (schedule_item(cmd, arr, bst, rec)) begin
      pending_slices.push_back(typed ? typed_rec : rec);
    end
    if (cmd == CMD_STEP || cmd == CMD_CLEAR || (cmd == CMD_LOAD && bst != 0)) begin
      items_sent++;
    end else begin
      ignored_sent++;
    end
  endtask

  // Holds the sender until every expected record is in, then lets the block settle.
  task automatic drain_results(input int extra);
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_slices.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_quanta(input logic [QNT_W-1:0] q1, input logic [QNT_W-1:0] q2);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_QUANTUM_ONE;
    cfg_data  <= q1;
    @(posedge clk);
    quantum_one = q1;
    cfg_index <= CFG_QUANTUM_TWO;
    cfg_data  <= q2;
    @(posedge clk);
    quantum_two = q2;
    cfg_we <= 1'b0;
  endtask

  // One workload: optional clear, a batch of loads, then steps until all complete or the cap is hit.
  task automatic run_workload(input int n_load);
    int steps;
    int step_cap;
    int arr_mode;
    int pick;
    logic [ARR_W-1:0]   arr;
    logic [BURST_W-1:0] bst;
    calm = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 3) != 0) begin
      send_item(CMD_CLEAR, ARR_W'($urandom), BURST_W'($urandom), 1'b0, '0);
    end
    arr_mode = $urandom_range(0, 3);
    for (int k = 0; k < n_load; k++) begin
      // Occasional items that the block must ignore.
      if ($urandom_range(0, 19) == 0) begin
        send_item(CMD_UNUSED, ARR_W'($urandom), BURST_W'($urandom), 1'b0, '0);
      end
      if ($urandom_range(0, 19) == 0) send_item(CMD_LOAD, ARR_W'($urandom), 16'd0, 1'b0, '0);
      case (arr_mode)
        0: arr = '0;
        1: arr = ARR_W'($urandom_range(0, 6));
        2: arr = ARR_W'($urandom_range(0, 24));
        default: arr = ($urandom_range(0, 3) == 0) ? ARR_W'($urandom_range(0, 65535))
                                                   : ARR_W'($urandom_range(0, 10));
      endcase
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        bst = BURST_W'($urandom_range(1, 65535));
      end else if (pick == 1) begin
        bst = 16'hFFFF;
      end else begin
        bst = BURST_W'($urandom_range(1, 12));
      end
      send_item(CMD_LOAD, arr, bst, 1'b0, '0);
    end
    // Far-off arrivals can stall a workload; the cap abandons it to the next clear.
    step_cap = 4 * n_load + 24;
    steps = 0;
    while (procs_finished < procs_loaded && steps < step_cap) begin
      if ($urandom_range(0, 29) == 0) drain_results(0);
      if ($urandom_range(0, 24) == 0) begin
        send_item(CMD_LOAD, ARR_W'($urandom_range(0, 30)), BURST_W'($urandom_range(1, 12)),
                  1'b0, '0);
      end else if ($urandom_range(0, 29) == 0) begin
        send_item(CMD_UNUSED, ARR_W'($urandom), BURST_W'($urandom), 1'b0, '0);
      end
      send_item(CMD_STEP, ARR_W'($urandom), BURST_W'($urandom), 1'b0, '0);
      steps++;
    end
    if ($urandom_range(0, 1) == 1) begin
      send_item(CMD_STEP, ARR_W'($urandom), BURST_W'($urandom), 1'b0, '0);
    end
  endtask

  // Stimulus and end of run.
  initial begin
    logic [QNT_W-1:0] q1;
    logic [QNT_W-1:0] q2;
    int target;
    bit first;
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.cmd          <= CMD_LOAD;
    in_if.arrival_time <= '0;
    in_if.burst_time   <= '0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_QUANTUM_ONE;
    cfg_data           <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < NUM_DIRECTED; r++) begin
      send_item(directed_rows[r].cmd, directed_rows[r].arrival, directed_rows[r].burst,
                directed_rows[r].typed, directed_rows[r].rec);
    end

    first = 1'b1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        drain_results(SETTLE_CYCLES);
        q1 = phase_q1[p];
        q2 = phase_q2[p];
        if (p == NUM_PHASES - 1) begin
          q1 = QNT_W'($urandom_range(1, 20));
          q2 = QNT_W'($urandom_range(1, 40));
        end
        write_quanta(q1, q2);
      end
      target = NUM_DIRECTED + (p + 1) * (TOTAL_ITEMS - NUM_DIRECTED) / NUM_PHASES;
      while (items_sent < target) begin
        // The first workload overfills the table.
        if (first) begin
          run_workload(18);
          first = 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          run_workload($urandom_range(17, 20));
        end else begin
          run_workload($urandom_range(1, 16));
        end
      end
    end

    drain_results(SETTLE_CYCLES);
    $display("Sent %0d items plus %0d ignored ones over %0d quantum settings.",
             items_sent, ignored_sent, NUM_PHASES);
    $display("Checked %0d ran, %0d idle and %0d all-done slices; %0d processes completed.",
             ran_slices, idle_slices, done_slices, completions);
    if (mismatch_count == 0 && pending_slices.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Result side: random stalls on ready, and every accepted record checked in order.
  initial begin
    int stall;
    slice_rec_t want;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
      if (pending_slices.size() == 0) begin
        mismatch_count++;
        $display("%0t: slice record with none expected, got kind %0d start %0d",
                 $time, out_if.slice_kind, out_if.start_tick);
      end else begin
        want = pending_slices.pop_front();
        check_field("slice_kind", want.kind, out_if.slice_kind);
        check_field("process_id", want.pid, out_if.process_id);
        check_field("start_tick", want.start_t, out_if.start_tick);
        check_field("end_tick", want.end_t, out_if.end_tick);
        check_field("queue_level", want.level, out_if.queue_level);
        check_field("finished", want.done_flag, out_if.finished);
        check_field("turnaround", want.tat, out_if.turnaround);
        check_field("waiting", want.wait_ticks, out_if.waiting);
        check_field("response", want.resp, out_if.response);
        case (want.kind)
          KIND_RAN:  ran_slices++;
          KIND_IDLE: idle_slices++;
          default:   done_slices++;
        endcase
        if (want.done_flag) completions++;
      end
    end
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mlfq_pkg.sv
hdl/mlfq_if.sv
hdl/mlfq_cell.sv
hdl/mlfq_cpu_scheduler_top.sv
tb/tb.sv
